// File: rtl/tst_pkg.sv
`timescale 1ns / 1ps

package tst_pkg;

  // fixed widths of the request and result fields
  localparam int TIME_W       = 32;
  localparam int IN_TAG_W     = 8;
  localparam int SLOT_FIELD_W = 5;
  localparam int TAG_FIELD_W  = 8;

  // request kinds
  typedef enum logic {
    REQ_POST = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_POSTED = 2'd0,
    ST_FULL   = 2'd1,
    ST_FIRED  = 2'd2,
    ST_DONE   = 2'd3
  } status_t;

endpackage

// File: rtl/tst_in_if.sv
`timescale 1ns / 1ps

interface tst_in_if
  import tst_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [TIME_W-1:0]   now_time;
  logic [TIME_W-1:0]   period;
  logic                one_shot;
  logic [IN_TAG_W-1:0] handler_tag;

  modport source (output valid, req_type, now_time, period, one_shot, handler_tag,
                  input ready);
  modport sink   (input valid, req_type, now_time, period, one_shot, handler_tag,
                  output ready);
endinterface

// File: rtl/tst_out_if.sv
`timescale 1ns / 1ps

interface tst_out_if
  import tst_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [TAG_FIELD_W-1:0]  fired_tag;
  logic                    last;

  modport source (output valid, status, slot, fired_tag, last, input ready);
  modport sink   (input valid, status, slot, fired_tag, last, output ready);
endinterface

// File: rtl/timer_slot_table_core.sv
`timescale 1ns / 1ps
// post: the request is taken, then the walk steps over each used slot below the lowest
//   free one; the posted or full result follows
// tick: walks every slot; a free slot is skipped and a used one goes through a memory
//   read, then due check and write back on a periodic firing, and the done result closes
//   the walk; a stalled result sink holds the walk
// reset clears the used flags at once; the slot memory is not cleared and needs no pass

module timer_slot_table_core
  import tst_pkg::*;
#(
  parameter int SLOTS    = 32,
  parameter int TAG_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  tst_in_if.sink    req,
  tst_out_if.source res
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = TAG_BITS + 1 + 2 * TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_POST    = 5'b00010,
    S_TICK_RD = 5'b00100,
    S_TICK_EV = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    idx;
  logic [SLOTS-1:0]    used;
  status_t             fin_status;

  // latched request
  logic [TIME_W-1:0]   req_now;
  logic [TIME_W-1:0]   req_period;
  logic                req_single;
  logic [TAG_BITS-1:0] req_tag;

  // result register
  logic                    o_valid;
  logic                    o_valid_next;
  status_t                 o_status;
  logic [SLOT_FIELD_W-1:0] o_slot;
  logic [TAG_FIELD_W-1:0]  o_tag;
  logic                    o_last;

  // slot memory: {tag, one-shot, period, last fire time}
  logic [ENTRY_W-1:0]  mem [SLOTS];
  logic [ENTRY_W-1:0]  rd_data;
  logic                mem_we;
  logic [ENTRY_W-1:0]  mem_wdata;

  logic [TIME_W-1:0]   rd_last;
  logic [TIME_W-1:0]   rd_period;
  logic                rd_single;
  logic [TAG_BITS-1:0] rd_tag;
  logic [TIME_W-1:0]   due;
  logic                due_hit;
  logic                out_free;

  assign rd_last   = rd_data[TIME_W-1:0];
  assign rd_period = rd_data[2*TIME_W-1:TIME_W];
  assign rd_single = rd_data[2*TIME_W];
  assign rd_tag    = rd_data[ENTRY_W-1:2*TIME_W+1];

  // due time wraps to the time width before the compare
  assign due      = rd_last + rd_period;
  assign due_hit  = (due <= req_now);
  assign out_free = !o_valid || res.ready;

  assign req.ready     = (state == S_IDLE);
  assign res.valid     = o_valid;
  assign res.status    = o_status;
  assign res.slot      = o_slot;
  assign res.fired_tag = o_tag;
  assign res.last      = o_last;

  // write back: new entry on a claim, fresh fire time on a periodic firing
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {req_tag, req_single, req_period, req_now};
    if (state == S_POST && !used[idx] && out_free) begin
      mem_we = 1'b1;
    end else if (state == S_TICK_EV && due_hit && !rd_single && out_free) begin
      mem_we    = 1'b1;
      mem_wdata = {rd_tag, rd_single, rd_period, req_now};
    end
  end

  // result valid: held until taken, set when a claim, firing or close is produced
  always_comb begin
    o_valid_next = o_valid && !res.ready;
    if (out_free && ((state == S_POST && !used[idx]) ||
                     (state == S_TICK_EV && due_hit) ||
                     (state == S_FINISH))) begin
      o_valid_next = 1'b1;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= mem_wdata;
    end
    rd_data <= mem[idx];
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      unique case (state)
        S_POST: begin
          o_status <= ST_POSTED;
          o_slot   <= SLOT_FIELD_W'(idx);
          o_tag    <= TAG_FIELD_W'(req_tag);
          o_last   <= 1'b1;
        end
        S_TICK_EV: begin
          o_status <= ST_FIRED;
          o_slot   <= SLOT_FIELD_W'(idx);
          o_tag    <= TAG_FIELD_W'(rd_tag);
          o_last   <= 1'b0;
        end
        S_FINISH: begin
          o_status <= fin_status;
          o_slot   <= '0;
          o_tag    <= '0;
          o_last   <= 1'b1;
        end
        default: begin
          o_status <= o_status;
        end
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_now    <= req.now_time;
      req_period <= req.period;
      req_single <= req.one_shot;
      req_tag    <= TAG_BITS'(req.handler_tag);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      used       <= '0;
      o_valid    <= 1'b0;
      fin_status <= ST_DONE;
    end else begin
      o_valid <= o_valid_next;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            idx   <= '0;
            state <= (req.req_type == REQ_TICK) ? S_TICK_RD : S_POST;
          end
        end
        S_POST: begin
          // claim the lowest free slot
          if (!used[idx]) begin
            if (out_free) begin
              used[idx] <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (idx == LAST_IDX) begin
            fin_status <= ST_FULL;
            state      <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TICK_RD: begin
          // used slots go through a memory read, free ones are skipped
          if (used[idx]) begin
            state <= S_TICK_EV;
          end else if (idx == LAST_IDX) begin
            fin_status <= ST_DONE;
            state      <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TICK_EV: begin
          if (!due_hit || out_free) begin
            if (due_hit && rd_single) begin
              used[idx] <= 1'b0;
            end
            if (idx == LAST_IDX) begin
              fin_status <= ST_DONE;
              state      <= S_FINISH;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_TICK_RD;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a claimed slot is marked used on the next cycle
  a_claim_marks_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST && !used[idx] && out_free) |=> used[$past(idx)])
    else $error("claimed slot not marked used");

  // only the closing result of a request carries last
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_status == ST_FIRED) |-> !o_last)
    else $error("fired result marked last");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request accepted without starting work");

  // memory is written only on a claim or a periodic firing
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (out_free && (state == S_POST || state == S_TICK_EV)))
    else $error("unexpected slot memory write");

endmodule
